FILE: rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define MBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under active-low reset
`define MBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/mbe_pkg.sv
package mbe_pkg;

    localparam int Q_W       = 32;
    localparam int FRAC_W    = 24;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 42;
    localparam int PIX_W     = 10;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W    = 13;
    localparam int MAG_W     = 12;
    localparam int QUO_W     = MAG_W + FRAC_W;
    localparam int WHOLE_W   = FRAC_W - 1;
    localparam int HI_W      = MAG_W + WHOLE_W;
    localparam int RDIV_W    = 10;
    localparam int X_W       = MAG_W + RDIV_W;
    localparam int RCP_W     = 32;
    localparam int DIV_STEPS = 3;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
    localparam int THR_SHIFT = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_THR    = 1'b1;

    localparam logic [CFG_W-1:0] LIMIT_RST = 8'd100;
    localparam logic [CFG_W-1:0] THR_RST   = 8'd12;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ITER = 5'b00100,
        S_SQR  = 5'b01000,
        S_SQI  = 5'b10000
    } t_state;

    function automatic t_q sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(Q_MAX);
        lo = SUM_W'(Q_MIN);
        if (v > hi) begin
            return Q_MAX;
        end else if (v < lo) begin
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

FILE: rtl/mbe_pix_if.sv
interface mbe_pix_if;
    logic                        valid;
    logic                        ready;
    logic [mbe_pkg::PIX_W-1:0]   pixel_row;
    logic [mbe_pkg::PIX_W-1:0]   pixel_col;

    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

FILE: rtl/mbe_res_if.sv
interface mbe_res_if;
    logic                        valid;
    logic                        ready;
    logic                        in_set;
    logic [mbe_pkg::CNT_W-1:0]   iteration_count;

    modport source (output valid, output in_set, output iteration_count, input ready);
    modport sink   (input valid, input in_set, input iteration_count, output ready);
endinterface

FILE: rtl/mbe_coord_div.sv
module mbe_coord_div #(
    parameter int RESOLUTION = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mbe_pkg::PIX_W-1:0] i_pix,
    output logic                      o_busy,
    output mbe_pkg::t_q               o_c
);

    localparam int     Div  = (RESOLUTION / 4 > 0) ? RESOLUTION / 4 : 1;
    localparam int     Half = RESOLUTION / 2;
    localparam longint Unit = 64'sd1 <<< mbe_pkg::FRAC_W;
    localparam logic [mbe_pkg::WHOLE_W-1:0] Whole = mbe_pkg::WHOLE_W'(Unit / Div);
    localparam logic [mbe_pkg::RDIV_W-1:0]  Frac  = mbe_pkg::RDIV_W'(Unit % Div);
    localparam logic [mbe_pkg::RCP_W-1:0]   Recip =
        mbe_pkg::RCP_W'(((64'sd1 <<< mbe_pkg::RCP_W) + Div - 1) / Div);

    logic                             r_busy;
    logic [mbe_pkg::DCNT_W-1:0]       r_cnt;
    logic [mbe_pkg::MAG_W-1:0]        r_mag;
    logic                             r_neg;
    logic [mbe_pkg::QUO_W-1:0]        r_hi;
    logic [mbe_pkg::X_W-1:0]          r_x;
    logic [mbe_pkg::X_W-1:0]          r_lo;
    logic [mbe_pkg::QUO_W-1:0]        r_quo;

    logic signed [mbe_pkg::DIFF_W-1:0]           diff;
    logic [mbe_pkg::DIFF_W-1:0]                  diff_abs;
    logic [mbe_pkg::HI_W-1:0]                    hi_prod;
    logic [mbe_pkg::X_W-1:0]                     x_prod;
    logic [mbe_pkg::X_W+mbe_pkg::RCP_W-1:0]      lo_prod;

    // |d| * 2^24 / div as |d| * whole + (|d| * frac) / div, the last by reciprocal
    always_comb begin
        diff      = $signed({{(mbe_pkg::DIFF_W - mbe_pkg::PIX_W){1'b0}}, i_pix})
                    - $signed(mbe_pkg::DIFF_W'(Half));
        diff_abs  = diff[mbe_pkg::DIFF_W-1] ? mbe_pkg::DIFF_W'(-diff)
                                            : mbe_pkg::DIFF_W'(diff);
        hi_prod   = {{mbe_pkg::WHOLE_W{1'b0}}, r_mag} * {{mbe_pkg::MAG_W{1'b0}}, Whole};
        x_prod    = {{mbe_pkg::RDIV_W{1'b0}}, r_mag} * {{mbe_pkg::MAG_W{1'b0}}, Frac};
        lo_prod   = {{mbe_pkg::RCP_W{1'b0}}, r_x} * {{mbe_pkg::X_W{1'b0}}, Recip};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= mbe_pkg::DCNT_W'(mbe_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == mbe_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= diff_abs[mbe_pkg::MAG_W-1:0];
            r_neg <= diff[mbe_pkg::DIFF_W-1];
        end else if (r_busy) begin
            r_hi  <= mbe_pkg::QUO_W'(hi_prod);
            r_x   <= x_prod;
            r_lo  <= lo_prod[mbe_pkg::X_W+mbe_pkg::RCP_W-1:mbe_pkg::RCP_W];
            r_quo <= r_hi + mbe_pkg::QUO_W'(r_lo);
        end
    end

    // truncate toward zero, then clamp to q8.24
    always_comb begin
        if (!r_neg) begin
            if (|r_quo[mbe_pkg::QUO_W-1:mbe_pkg::Q_W-1]) begin
                o_c = mbe_pkg::Q_MAX;
            end else begin
                o_c = $signed(r_quo[mbe_pkg::Q_W-1:0]);
            end
        end else begin
            if ((|r_quo[mbe_pkg::QUO_W-1:mbe_pkg::Q_W])
                || (r_quo[mbe_pkg::Q_W-1] && (|r_quo[mbe_pkg::Q_W-2:0]))) begin
                o_c = mbe_pkg::Q_MIN;
            end else begin
                o_c = $signed(-r_quo[mbe_pkg::Q_W-1:0]);
            end
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/mandelbrot_escape_time_unit.sv
// channel   dir   word                            handshake
// i_pix     in    pixel_row, pixel_col            valid/ready
// o_res     out   in_set, iteration_count         valid/ready
// cfg       in    i_cfg_idx, i_cfg_data           i_cfg_we, no stall
//
// one pixel at a time: coordinate scaling (constant reciprocal multiply), then
// iterations that each step through S_ITER, S_SQR and S_SQI on the shared 32x32
// multiplier, and a final check in S_ITER that loads the output register
// ready is high only while idle; a finished word waits in the output register,
// the next pixel may be taken meanwhile, and its final check holds until it frees
// reset loads iteration_limit 100 and escape_threshold 12
module mandelbrot_escape_time_unit #(
    parameter int RESOLUTION = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mbe_pkg::CFG_W-1:0]     i_cfg_data,
    mbe_pix_if.sink                       i_pix,
    mbe_res_if.source                     o_res
);

    mbe_pkg::t_state              r_state;
    logic [mbe_pkg::CFG_W-1:0]    r_limit;
    logic [mbe_pkg::CFG_W-1:0]    r_thr;
    mbe_pkg::t_q                  r_zr;
    mbe_pkg::t_q                  r_zi;
    mbe_pkg::t_prod               r_sqr;
    mbe_pkg::t_prod               r_sqi;
    mbe_pkg::t_prod               r_prod;
    logic [mbe_pkg::CNT_W-1:0]    r_k;
    logic                         r_out_valid;
    logic                         r_out_set;
    logic [mbe_pkg::CNT_W-1:0]    r_out_cnt;

    logic                         accept;
    logic                         busy_row;
    logic                         busy_col;
    mbe_pkg::t_q                  ci;
    mbe_pkg::t_q                  cr;
    mbe_pkg::t_q                  mul_a;
    mbe_pkg::t_q                  mul_b;
    mbe_pkg::t_prod               mul_p;
    mbe_pkg::t_prod               sq_diff;
    logic signed [mbe_pkg::SUM_W-1:0] nr_sum;
    logic signed [mbe_pkg::SUM_W-1:0] ni_sum;
    mbe_pkg::t_q                  nr;
    mbe_pkg::t_q                  ni;
    logic [mbe_pkg::PROD_W-1:0]   mag;
    logic [mbe_pkg::PROD_W-1:0]   thr_mag;
    logic                         stop;
    logic                         slot_free;
    logic                         finish;

    assign accept    = i_pix.valid && i_pix.ready;
    assign slot_free = !r_out_valid || o_res.ready;
    assign finish    = (r_state == mbe_pkg::S_ITER) && stop && slot_free;

    mbe_coord_div #(.RESOLUTION(RESOLUTION)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_pix   (i_pix.pixel_row),
        .o_busy  (busy_row),
        .o_c     (ci)
    );

    mbe_coord_div #(.RESOLUTION(RESOLUTION)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_pix   (i_pix.pixel_col),
        .o_busy  (busy_col),
        .o_c     (cr)
    );

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            mbe_pkg::S_SQR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            mbe_pkg::S_SQI: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        sq_diff = r_sqr - r_sqi;
        nr_sum  = mbe_pkg::SUM_W'($signed(sq_diff[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_W]))
                  + mbe_pkg::SUM_W'(cr);
        ni_sum  = mbe_pkg::SUM_W'($signed(r_prod[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_W-1]))
                  + mbe_pkg::SUM_W'(ci);
        nr      = mbe_pkg::sat_q(nr_sum);
        ni      = mbe_pkg::sat_q(ni_sum);
        mag     = r_sqr + r_sqi;
        thr_mag = {{(mbe_pkg::PROD_W - mbe_pkg::CFG_W - mbe_pkg::THR_SHIFT){1'b0}},
                   r_thr, {mbe_pkg::THR_SHIFT{1'b0}}};
        stop    = (r_k != '0) && ((mag >= thr_mag) || (r_k >= r_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mbe_pkg::LIMIT_RST;
            r_thr   <= mbe_pkg::THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbe_pkg::REG_ITER_LIMIT: r_limit <= i_cfg_data;
                mbe_pkg::REG_ESC_THR:    r_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbe_pkg::S_IDLE;
        end else begin
            unique case (r_state)
                mbe_pkg::S_IDLE: begin
                    if (accept) begin
                        r_state <= mbe_pkg::S_DIV;
                    end
                end
                mbe_pkg::S_DIV: begin
                    if (!busy_row && !busy_col) begin
                        r_state <= mbe_pkg::S_ITER;
                    end
                end
                mbe_pkg::S_ITER: begin
                    if (stop) begin
                        if (slot_free) begin
                            r_state <= mbe_pkg::S_IDLE;
                        end
                    end else begin
                        r_state <= mbe_pkg::S_SQR;
                    end
                end
                mbe_pkg::S_SQR: r_state <= mbe_pkg::S_SQI;
                mbe_pkg::S_SQI: r_state <= mbe_pkg::S_ITER;
                default:        r_state <= mbe_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mbe_pkg::S_DIV: begin
                r_zr  <= '0;
                r_zi  <= '0;
                r_sqr <= '0;
                r_sqi <= '0;
                r_k   <= '0;
            end
            mbe_pkg::S_ITER: begin
                if (stop) begin
                    if (slot_free) begin
                        r_out_set <= (r_k >= r_limit);
                        r_out_cnt <= r_k;
                    end
                end else begin
                    r_prod <= mul_p;
                    r_zr   <= nr;
                    r_k    <= r_k + 1'b1;
                end
            end
            mbe_pkg::S_SQR: begin
                r_sqr <= mul_p;
                r_zi  <= ni;
            end
            mbe_pkg::S_SQI: begin
                r_sqi <= mul_p;
            end
            default: ;
        endcase
    end

    assign i_pix.ready           = (r_state == mbe_pkg::S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.in_set          = r_out_set;
    assign o_res.iteration_count = r_out_cnt;

endmodule

FILE: rtl/mbe_checker.sv
`include "assert_macros.svh"

module mbe_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_pix_valid,
    input logic                        i_pix_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_in_set,
    input logic [mbe_pkg::CNT_W-1:0]   i_res_count
);

    // a word never reports zero iterations
    `MBE_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, i_res_valid, i_res_count != '0)

    // one pixel at a time: busy right after taking a word
    `MBE_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_pix_valid && i_pix_ready, !i_pix_ready)

    `MBE_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    `MBE_ASSERT_NXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable({i_res_in_set, i_res_count}))

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pix_valid  (i_pix.valid),
    .i_pix_ready  (i_pix.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_in_set (o_res.in_set),
    .i_res_count  (o_res.iteration_count)
);
